// ----- hw/rtl/tmq_pkg.sv -----
// shared types and constants of the tagged message match queue
`default_nettype none

package tmq_pkg;

    localparam int KEY_W         = 64;
    localparam int HANDLE_W      = 16;
    localparam int COMM_W        = 16;
    localparam int RANK_W        = 16;
    localparam int TAG_W         = 32;
    localparam int COUNT_W       = 7;
    localparam int STATUS_W      = 2;
    localparam int STORE_ENTRIES = 64;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_FIND = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_MATCH = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

    // commands broadcast to every cell of the row
    typedef struct packed {
        logic cmp;
        logic add;
        logic find;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tmq_cell.sv -----
// one storage cell of the match row: key, handle, occupied bit and key compare
`default_nettype none

module tmq_cell (
    input  wire                            clk,
    input  wire                            rst_n,
    input  tmq_pkg::cell_ctrl_t            ctrl,
    input  wire  [tmq_pkg::KEY_W-1:0]      cmp_key,
    input  wire  [tmq_pkg::KEY_W-1:0]      wr_key,
    input  wire  [tmq_pkg::HANDLE_W-1:0]   wr_handle,
    input  wire                            prev_valid,
    input  wire                            hit_in,
    input  wire  [tmq_pkg::HANDLE_W-1:0]   hout_in,
    input  wire                            next_valid,
    input  wire  [tmq_pkg::KEY_W-1:0]      next_key,
    input  wire  [tmq_pkg::HANDLE_W-1:0]   next_handle,
    output logic                           valid,
    output logic [tmq_pkg::KEY_W-1:0]      key,
    output logic [tmq_pkg::HANDLE_W-1:0]   handle,
    output logic                           hit_out,
    output logic [tmq_pkg::HANDLE_W-1:0]   hout_out
);

    logic                            valid_reg;
    logic                            match_reg;
    logic [tmq_pkg::KEY_W-1:0]       key_reg;
    logic [tmq_pkg::HANDLE_W-1:0]    handle_reg;
    logic                            take;
    logic                            shift;
    logic                            write_here;

    // first matching cell hands out its handle, it and all later cells pull from the next
    assign take       = match_reg && !hit_in;
    assign shift      = match_reg || hit_in;
    assign write_here = !valid_reg && prev_valid;

    assign hit_out  = shift;
    assign hout_out = hout_in | (take ? handle_reg : '0);
    assign valid    = valid_reg;
    assign key      = key_reg;
    assign handle   = handle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.cmp)
            begin
                match_reg <= valid_reg && (key_reg == cmp_key);
            end
            if (ctrl.add && write_here)
            begin
                valid_reg <= 1'b1;
            end
            else if (ctrl.find && shift)
            begin
                valid_reg <= next_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.add && write_here)
        begin
            key_reg    <= wr_key;
            handle_reg <= wr_handle;
        end
        else if (ctrl.find && shift)
        begin
            key_reg    <= next_key;
            handle_reg <= next_handle;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tagged_early_message_match_queue.sv -----
// top level of the tagged early message match queue
// Stores early-arrived messages as (key, handle) pairs, oldest first, in a row
// of cells and matches receive posts against them.
// Input channel in_valid/in_ready carries one transaction per item: opcode
// (add or find), comm_id, source_rank, message_tag and handle_ref.
// Output channel out_valid/out_ready returns exactly one result per item:
// found, handle_out, status and pending_count.
// At the accept edge of an item, all cells compare their key against the
// item key in parallel and register the outcome; then, in S_EXEC once the
// output register is free, the first-hit signal ripples along the row, the
// hit cell hands out its handle and every later cell loads from its
// neighbor, and the result lands in the output register. A new item is
// accepted the cycle after that commit; the pace is set by the compare stage
// followed by the hit chain across STORE_ENTRIES cells.
// When the receiver stalls, a finished result waits in the output register;
// the next item may still be accepted and then waits for the register to
// free before it commits.
// Reset empties the store (all cells unoccupied, occupancy count zero) at once.
`default_nettype none

module tagged_early_message_match_queue #(
    parameter int STORE_ENTRIES = tmq_pkg::STORE_ENTRIES
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    output logic                               in_ready,
    input  wire                                opcode,
    input  wire  [tmq_pkg::COMM_W-1:0]         comm_id,
    input  wire  [tmq_pkg::RANK_W-1:0]         source_rank,
    input  wire  [tmq_pkg::TAG_W-1:0]          message_tag,
    input  wire  [tmq_pkg::HANDLE_W-1:0]       handle_ref,
    output logic                               out_valid,
    input  wire                                out_ready,
    output logic                               found,
    output logic [tmq_pkg::HANDLE_W-1:0]       handle_out,
    output logic [tmq_pkg::STATUS_W-1:0]       status,
    output logic [tmq_pkg::COUNT_W-1:0]        pending_count
);

    localparam int OCC_W  = $clog2(STORE_ENTRIES + 1);
    localparam int WIDE_W = OCC_W + tmq_pkg::COUNT_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t                            state_reg, state_next;
    logic [OCC_W-1:0]                  occ_reg, occ_next;
    logic                              op_reg;
    logic [tmq_pkg::KEY_W-1:0]         key_reg;
    logic [tmq_pkg::HANDLE_W-1:0]      handle_reg;

    logic                              out_valid_reg, out_valid_next;
    logic                              found_reg;
    logic [tmq_pkg::HANDLE_W-1:0]      hout_reg;
    logic [tmq_pkg::STATUS_W-1:0]      status_reg;
    logic [tmq_pkg::COUNT_W-1:0]       count_reg;

    logic                              found_next;
    logic [tmq_pkg::HANDLE_W-1:0]      hout_next;
    logic [tmq_pkg::STATUS_W-1:0]      status_next;
    logic [tmq_pkg::COUNT_W-1:0]       count_next;
    logic [WIDE_W-1:0]                 occ_wide;

    logic                              accept;
    logic                              commit;
    logic                              full;
    tmq_pkg::cell_ctrl_t               ctrl;
    logic [tmq_pkg::KEY_W-1:0]         in_key;

    logic [STORE_ENTRIES:0]            valid_a;
    logic [STORE_ENTRIES:0]            hit_a;
    logic [tmq_pkg::KEY_W-1:0]         key_a  [STORE_ENTRIES+1];
    logic [tmq_pkg::HANDLE_W-1:0]      hdl_a  [STORE_ENTRIES+1];
    logic [tmq_pkg::HANDLE_W-1:0]      hout_a [STORE_ENTRIES+1];

    assign in_key   = {comm_id, source_rank, message_tag};
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign commit   = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
    assign full     = (occ_reg == OCC_W'(STORE_ENTRIES));

    assign ctrl.cmp  = accept;
    assign ctrl.add  = commit && (op_reg == tmq_pkg::OP_ADD);
    assign ctrl.find = commit && (op_reg == tmq_pkg::OP_FIND);

    // row boundaries: head sees an occupied predecessor, tail pulls an empty cell
    assign hit_a[0]                = 1'b0;
    assign hout_a[0]               = '0;
    assign valid_a[STORE_ENTRIES]  = 1'b0;
    assign key_a[STORE_ENTRIES]    = '0;
    assign hdl_a[STORE_ENTRIES]    = '0;

    genvar g;
    generate
        for (g = 0; g < STORE_ENTRIES; g++)
        begin : g_cell
            tmq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .cmp_key     (in_key),
                .wr_key      (key_reg),
                .wr_handle   (handle_reg),
                .prev_valid  ((g == 0) ? 1'b1 : valid_a[(g == 0) ? 0 : g-1]),
                .hit_in      (hit_a[g]),
                .hout_in     (hout_a[g]),
                .next_valid  (valid_a[g+1]),
                .next_key    (key_a[g+1]),
                .next_handle (hdl_a[g+1]),
                .valid       (valid_a[g]),
                .key         (key_a[g]),
                .handle      (hdl_a[g]),
                .hit_out     (hit_a[g+1]),
                .hout_out    (hout_a[g+1])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        out_valid_next = out_valid_reg;
        found_next     = 1'b0;
        hout_next      = '0;
        status_next    = tmq_pkg::STATUS_OK;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    if (op_reg == tmq_pkg::OP_ADD)
                    begin
                        if (full)
                        begin
                            status_next = tmq_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            occ_next = occ_reg + OCC_W'(1);
                        end
                    end
                    else
                    begin
                        if (hit_a[STORE_ENTRIES])
                        begin
                            found_next = 1'b1;
                            hout_next  = hout_a[STORE_ENTRIES];
                            occ_next   = occ_reg - OCC_W'(1);
                        end
                        else
                        begin
                            status_next = tmq_pkg::STATUS_NO_MATCH;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // count saturates at the field maximum
    assign occ_wide   = WIDE_W'(occ_next);
    assign count_next = (occ_wide > WIDE_W'(tmq_pkg::COUNT_MAX)) ? tmq_pkg::COUNT_MAX
                                                                  : occ_wide[tmq_pkg::COUNT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= opcode;
            key_reg    <= in_key;
            handle_reg <= handle_ref;
        end
        if (commit)
        begin
            found_reg  <= found_next;
            hout_reg   <= hout_next;
            status_reg <= status_next;
            count_reg  <= count_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign handle_out    = hout_reg;
    assign status        = status_reg;
    assign pending_count = count_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/tmq_checker.sv -----
// port-level checks of the tagged early message match queue, bound to the top level
`default_nettype none

module tmq_checker (
    input wire                               clk,
    input wire                               rst_n,
    input wire                               in_valid,
    input wire                               in_ready,
    input wire                               out_valid,
    input wire                               out_ready,
    input wire                               found,
    input wire [tmq_pkg::HANDLE_W-1:0]       handle_out,
    input wire [tmq_pkg::STATUS_W-1:0]       status,
    input wire [tmq_pkg::COUNT_W-1:0]        pending_count
);

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(handle_out) && $stable(status))
    else $error("result changed while stalled");

    // a hit always reports ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> status == tmq_pkg::STATUS_OK)
    else $error("found with non-ok status");

    // no hit means no handle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> handle_out == '0)
    else $error("handle driven without a hit");

    // one item in flight: busy in the cycle after an accepted transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

    // a refused add only happens with a full, nonempty store
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == tmq_pkg::STATUS_FULL |-> pending_count != '0)
    else $error("full refusal with an empty store");

endmodule

bind tagged_early_message_match_queue tmq_checker u_tmq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .found         (found),
    .handle_out    (handle_out),
    .status        (status),
    .pending_count (pending_count)
);

`default_nettype wire
